@@ rtl/lfpr_pkg.sv @@
// lfpr_pkg: shared constants, types and state codes of the length framed packet receiver
// no dependencies; used by lfpr_if, lfpr_ctrl, lfpr_dp and the top level (lfpr_ram does not use it)

package lfpr_pkg;

   localparam int ByteWidth   = 8;
   localparam int MaxPayload  = 32;
   localparam int StoreSlots  = 32;
   localparam int Capacity    = (MaxPayload < StoreSlots) ? MaxPayload : StoreSlots;
   localparam int AddrWidth   = $clog2(StoreSlots);

   localparam logic [ByteWidth-1:0] ResetStartMarker = 8'h13;
   localparam logic [ByteWidth-1:0] ResetEndMarker   = 8'h37;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [AddrWidth-1:0] addr_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_index_type;

   // receiver phase
   typedef enum logic [2:0] {
      PH_START,
      PH_LENGTH,
      PH_COMMAND,
      PH_DATA,
      PH_END,
      PH_EMIT
   } phase_type;

   // controller to datapath
   typedef struct packed {
      logic take_start;
      logic take_length;
      logic take_command;
      logic take_data;
      logic take_end;
      logic emit_step;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic length_zero;
      logic data_last;
      logic emit_last;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/lfpr_if.sv @@
// lfpr_req_if / lfpr_rsp_if: valid/ready channels of the packet receiver
// depends on lfpr_pkg for field widths

interface lfpr_req_if;
   logic                              valid;
   logic                              ready;
   logic [lfpr_pkg::ByteWidth-1:0]    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfpr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lfpr_pkg::ByteWidth-1:0]    command;
   logic [lfpr_pkg::ByteWidth-1:0]    frame_length;
   logic                              markers_ok;
   logic                              truncated;
   logic                              has_data;
   logic [lfpr_pkg::AddrWidth-1:0]    byte_index;
   logic [lfpr_pkg::ByteWidth-1:0]    data_byte;
   logic                              last;

   modport source (output valid, output command, output frame_length, output markers_ok,
                   output truncated, output has_data, output byte_index, output data_byte,
                   output last, input ready);
   modport sink   (input valid, input command, input frame_length, input markers_ok,
                   input truncated, input has_data, input byte_index, input data_byte,
                   input last, output ready);
endinterface

@@ rtl/lfpr_ram.sv @@
// lfpr_ram: generic single write port ram with registered, enabled read
// no dependencies

module lfpr_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lfpr_ctrl.sv @@
// lfpr_ctrl: phase state machine of the packet receiver, issues datapath commands
// depends on lfpr_pkg

module lfpr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lfpr_pkg::dp_status_type status,
   output lfpr_pkg::ctrl_cmd_type  cmd
);

   import lfpr_pkg::*;

   phase_type state_ff;
   phase_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_START;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PH_START: begin
            if (accept) state_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (accept) state_in = PH_COMMAND;
         end
         PH_COMMAND: begin
            if (accept) state_in = PH_DATA;
         end
         PH_DATA: begin
            if (accept && (status.length_zero || status.data_last)) state_in = PH_END;
         end
         PH_END: begin
            if (accept) state_in = PH_EMIT;
         end
         PH_EMIT: begin
            if (status.out_free && status.emit_last) state_in = PH_START;
         end
         default: begin
            state_in = PH_START;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         PH_START: begin
            req_ready      = 1'b1;
            cmd.take_start = req_valid;
         end
         PH_LENGTH: begin
            req_ready       = 1'b1;
            cmd.take_length = req_valid;
         end
         PH_COMMAND: begin
            req_ready        = 1'b1;
            cmd.take_command = req_valid;
         end
         PH_DATA: begin
            req_ready     = 1'b1;
            cmd.take_data = req_valid;
         end
         PH_END: begin
            req_ready    = 1'b1;
            cmd.take_end = req_valid;
         end
         PH_EMIT: begin
            cmd.emit_step = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // at most one datapath action per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_start, cmd.take_length, cmd.take_command,
                cmd.take_data, cmd.take_end, cmd.emit_step}))
      else $error("more than one datapath command at once");

   // no input taken while a frame is being read out
   a_no_take_in_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_step || state_ff == PH_EMIT) |-> !accept)
      else $error("input accepted during readout");

   // the end byte always starts a readout
   a_end_to_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.take_end |=> (state_ff == PH_EMIT))
      else $error("end byte did not start readout");

endmodule

@@ rtl/lfpr_dp.sv @@
// lfpr_dp: frame fields, marker registers, payload store and result register
// depends on lfpr_pkg, lfpr_rsp_if and lfpr_ram

module lfpr_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  lfpr_pkg::byte_type             rx_byte,
   input  lfpr_pkg::ctrl_cmd_type         cmd,
   output lfpr_pkg::dp_status_type        status,
   input  logic                           csr_write_en,
   input  lfpr_pkg::csr_index_type        csr_index,
   input  lfpr_pkg::byte_type             csr_write_data,
   lfpr_rsp_if.source                     rsp
);

   import lfpr_pkg::*;

   localparam byte_type CapacityByte = ByteWidth'(Capacity);

   byte_type start_marker_ff;
   byte_type end_marker_ff;
   logic     start_matched_ff;
   byte_type length_field_ff;
   byte_type command_field_ff;
   byte_type byte_count_ff;

   // readout context of the finished frame
   logic     em_ok_ff;
   logic     em_trunc_ff;
   logic     em_has_data_ff;
   addr_type em_last_idx_ff;
   addr_type em_ptr_ff;

   // result register
   logic     rsp_valid_ff;
   byte_type rsp_command_ff;
   byte_type rsp_length_ff;
   logic     rsp_ok_ff;
   logic     rsp_trunc_ff;
   logic     rsp_has_data_ff;
   addr_type rsp_index_ff;
   logic     rsp_last_ff;

   byte_type stored;
   addr_type last_idx;
   logic     ram_wr_en;
   byte_type ram_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= ResetStartMarker;
         end_marker_ff   <= ResetEndMarker;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_write_data;
            CSR_END_MARKER:   end_marker_ff   <= csr_write_data;
            default:          ;
         endcase
      end
   end

   assign stored   = (length_field_ff < CapacityByte) ? length_field_ff : CapacityByte;
   assign last_idx = (stored == '0) ? '0 : AddrWidth'(stored - 8'd1);

   // frame capture
   always_ff @(posedge clock) begin
      if (reset) begin
         start_matched_ff <= 1'b0;
         length_field_ff  <= '0;
         command_field_ff <= '0;
         byte_count_ff    <= '0;
      end else begin
         if (cmd.take_start) begin
            start_matched_ff <= (rx_byte == start_marker_ff);
            byte_count_ff    <= '0;
         end
         if (cmd.take_length)  length_field_ff  <= rx_byte;
         if (cmd.take_command) command_field_ff <= rx_byte;
         if (cmd.take_data && !status.length_zero && !status.data_last) begin
            byte_count_ff <= byte_count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_end) begin
         em_ok_ff       <= start_matched_ff && (rx_byte == end_marker_ff);
         em_trunc_ff    <= (length_field_ff > CapacityByte);
         em_has_data_ff <= (stored != '0);
         em_last_idx_ff <= last_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_ptr_ff <= '0;
      end else if (cmd.take_end) begin
         em_ptr_ff <= '0;
      end else if (cmd.emit_step) begin
         em_ptr_ff <= em_ptr_ff + 1'b1;
      end
   end

   assign ram_wr_en = cmd.take_data && !status.length_zero && (byte_count_ff < CapacityByte);

   lfpr_ram #(
      .Width (ByteWidth),
      .Depth (StoreSlots)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (byte_count_ff[AddrWidth-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.emit_step),
      .rd_addr (em_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         rsp_command_ff  <= command_field_ff;
         rsp_length_ff   <= length_field_ff;
         rsp_ok_ff       <= em_ok_ff;
         rsp_trunc_ff    <= em_trunc_ff;
         rsp_has_data_ff <= em_has_data_ff;
         rsp_index_ff    <= em_has_data_ff ? em_ptr_ff : '0;
         rsp_last_ff     <= (em_ptr_ff == em_last_idx_ff);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.command      = rsp_command_ff;
   assign rsp.frame_length = rsp_length_ff;
   assign rsp.markers_ok   = rsp_ok_ff;
   assign rsp.truncated    = rsp_trunc_ff;
   assign rsp.has_data     = rsp_has_data_ff;
   assign rsp.byte_index   = rsp_index_ff;
   assign rsp.data_byte    = rsp_has_data_ff ? ram_rd_data : '0;
   assign rsp.last         = rsp_last_ff;

   assign status.length_zero = (length_field_ff == '0);
   assign status.data_last   = ({1'b0, byte_count_ff} + 9'd1) >= {1'b0, length_field_ff};
   assign status.emit_last   = (em_ptr_ff == em_last_idx_ff);
   assign status.out_free    = !rsp_valid_ff || rsp.ready;

   // byte counter never passes the received length
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (length_field_ff == '0) || (byte_count_ff < length_field_ff))
      else $error("byte count beyond frame length");

   // a readout step always leaves a result in the register
   a_step_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |=> rsp_valid_ff)
      else $error("readout step did not load result");

   // a result without data is the only and last one of its frame
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_data_ff) |-> (rsp_last_ff && rsp_index_ff == '0))
      else $error("empty result not last");

endmodule

@@ rtl/length_framed_packet_receiver_unit.sv @@
// length_framed_packet_receiver_unit: top level of the length framed packet receiver
// depends on lfpr_pkg, lfpr_if, lfpr_ctrl, lfpr_dp (which holds lfpr_ram)
// input: one byte per cycle outside readout; the end byte starts the registered readout
// throughput: a frame of n payload bytes takes max(n, 1) + 4 input transactions, then a
//    readout of max(min(n, 32), 1) results, one per cycle if rsp ready, input held off
// reset: markers return to 0x13 and 0x37, receiver waits for a start byte; payload store
//    is not cleared, only entries written by the current frame are ever output

module length_framed_packet_receiver_unit (
   input  logic                    clock,
   input  logic                    reset,
   lfpr_req_if.sink                req,
   lfpr_rsp_if.source              rsp,
   input  logic                    csr_write_en,
   input  lfpr_pkg::csr_index_type csr_index,
   input  lfpr_pkg::byte_type      csr_write_data
);

   import lfpr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          ready;

   // phase sequencing and readout pacing
   lfpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   // input transactions are taken only outside a readout burst
   assign req.ready = ready;

   // frame fields, payload store and the result register that drives rsp
   lfpr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req.rx_byte),
      .cmd            (cmd),
      .status         (status),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp            (rsp)
   );

endmodule
